// ----- hw/rtl/bcdf_pkg.sv -----
// Package for the BCD digit formatter: shared types, character codes and
// register indexes. No dependencies.
package bcdf_pkg;

    localparam int NUM_SLOTS = 4;

    // Character codes
    localparam logic [7:0] CODE_ZERO     = 8'hf6;
    localparam logic [7:0] CODE_CURRENCY = 8'hf0;
    localparam logic [7:0] CODE_SPACE    = 8'h7f;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_SUPPRESS = 2'd0,
        REG_LEFT     = 2'd1,
        REG_CURRENCY = 2'd2,
        REG_LENGTH   = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic       suppress;
        logic       left;
        logic       currency;
        logic [4:0] length;
    } cfg_t;

    // Per-number formatting state
    typedef struct packed {
        logic       blanking;
        logic       cur_pending;
        logic [5:0] column;
        logic [4:0] byte_idx;
    } fmt_state_t;

    typedef struct packed {
        logic [5:0] column;
        logic [7:0] code;
    } char_wr_t;

    // Writes caused by one byte, plus the state that follows it
    typedef struct packed {
        char_wr_t [NUM_SLOTS-1:0] wr;
        logic [2:0]               count;
        logic                     done;
        fmt_state_t               nxt;
    } expand_t;

endpackage

// ----- hw/rtl/bcd_digit_formatter_unit.sv -----
// Top level of the BCD digit formatter: config registers, write buffer and
// output register. Depends on bcdf_pkg and bcdf_expand.
//
// Usage: each item on the s_ channel is one packed BCD byte (high nibble
// first). length_bytes bytes form one number. Each byte yields zero to four
// character writes on the m_ channel as (column, code); m_tlast marks the
// last write of a byte, m_tuser the final write of the number.
// A byte is expanded in the cycle it is accepted into a four-entry write
// buffer; it drains one write per cycle into the output register unless stalled.
// Each write passes through the write buffer register and then the output
// register before it can be taken on the m_ channel.
// Throughput: one write per cycle while the receiver keeps up; the single
// buffer drain port sets that rate.
// A new byte is taken in the cycle the buffer hands over its last write.
// Reset clears the config to its defaults, the number state, the buffer counts and
// the output valid flag. When the receiver stalls, the output register holds and the
// buffer stops draining, so s_tready drops once the buffer is still busy.
// The user writes configuration through cfg_wr_en/cfg_index/cfg_wdata only while idle; the block does not enforce it.
module bcd_digit_formatter_unit #(
    parameter int MAX_BYTES = 31
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_wdata,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] bcd_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] column, [13:6] char_code, [15:14] zero
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // [0] number_done
);

    bcdf_pkg::cfg_t       cfg_reg;
    bcdf_pkg::fmt_state_t st_reg;
    bcdf_pkg::expand_t    exp_res;

    bcdf_pkg::char_wr_t [bcdf_pkg::NUM_SLOTS-1:0] buf_reg;
    logic [2:0] cnt_reg;
    logic [2:0] ptr_reg;
    logic       done_reg;

    logic [13:0] out_data_reg;
    logic        out_valid_reg;
    logic        out_last_reg;
    logic        out_done_reg;

    logic in_acc;
    logic pop;
    logic pop_last;
    logic [2:0] remain;

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{suppress: 1'b0, left: 1'b0, currency: 1'b0, length: 5'd1};
        end else if (cfg_wr_en) begin
            case (bcdf_pkg::reg_index_t'(cfg_index))
                bcdf_pkg::REG_SUPPRESS: cfg_reg.suppress <= cfg_wdata[0];
                bcdf_pkg::REG_LEFT:     cfg_reg.left     <= cfg_wdata[0];
                bcdf_pkg::REG_CURRENCY: cfg_reg.currency <= cfg_wdata[0];
                bcdf_pkg::REG_LENGTH:   cfg_reg.length   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    bcdf_expand #(
        .MAX_BYTES (MAX_BYTES)
    ) u_expand (
        .bcd_byte (s_tdata),
        .cfg      (cfg_reg),
        .cur      (st_reg),
        .res      (exp_res)
    );

    // Buffer handshake
    assign remain   = cnt_reg - ptr_reg;
    assign pop      = (remain != 3'd0) && (!out_valid_reg || m_tready);
    assign pop_last = pop && (remain == 3'd1);
    assign s_tready = (remain == 3'd0) || pop_last;
    assign in_acc   = s_tvalid && s_tready;

    // Number state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (in_acc) begin
            st_reg <= exp_res.nxt;
        end
    end

    // Write buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 3'd0;
            ptr_reg <= 3'd0;
        end else if (in_acc) begin
            cnt_reg <= exp_res.count;
            ptr_reg <= 3'd0;
        end else if (pop) begin
            ptr_reg <= ptr_reg + 3'd1;
        end
    end

    // Write buffer payload
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            buf_reg  <= exp_res.wr;
            done_reg <= exp_res.done;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= {buf_reg[ptr_reg[1:0]].code, buf_reg[ptr_reg[1:0]].column};
            out_last_reg <= (remain == 3'd1);
            out_done_reg <= (remain == 3'd1) && done_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule

// ----- hw/rtl/bcdf_expand.sv -----
// Expands one packed BCD byte into up to four character writes.
// Depends on bcdf_pkg.
module bcdf_expand #(
    parameter int MAX_BYTES = 31
) (
    input  logic [7:0]          bcd_byte,
    input  bcdf_pkg::cfg_t      cfg,
    input  bcdf_pkg::fmt_state_t cur,
    output bcdf_pkg::expand_t   res
);

    // Append one write at the running column
    function automatic bcdf_pkg::expand_t push(bcdf_pkg::expand_t e, logic [7:0] code);
        bcdf_pkg::expand_t r;
        r = e;
        r.wr[e.count[1:0]].column = e.nxt.column;
        r.wr[e.count[1:0]].code   = code;
        r.nxt.column = e.nxt.column + 6'd1;
        r.count      = e.count + 3'd1;
        return r;
    endfunction

    // One digit with leading-zero blanking
    function automatic bcdf_pkg::expand_t put_digit(bcdf_pkg::expand_t e, logic [3:0] d,
                                                    logic left);
        bcdf_pkg::expand_t r;
        r = e;
        if (d != 4'd0) begin
            if (r.nxt.blanking) begin
                if (r.nxt.cur_pending) begin
                    r = push(r, bcdf_pkg::CODE_CURRENCY);
                    r.nxt.cur_pending = 1'b0;
                end
                r.nxt.blanking = 1'b0;
            end
            r = push(r, bcdf_pkg::CODE_ZERO + {4'd0, d});
        end else if (!r.nxt.blanking) begin
            r = push(r, bcdf_pkg::CODE_ZERO);
        end else if (!left) begin
            r = push(r, bcdf_pkg::CODE_SPACE);
        end
        return r;
    endfunction

    localparam logic [5:0] MaxLen = 6'(MAX_BYTES);

    logic [5:0] len;
    logic       first;
    logic       last;

    // Out-of-range length acts as the maximum
    always_comb begin
        if (cfg.length == 5'd0 || {1'b0, cfg.length} > MaxLen) begin
            len = MaxLen;
        end else begin
            len = {1'b0, cfg.length};
        end
    end

    assign first = (cur.byte_idx == 5'd0);
    assign last  = ({1'b0, cur.byte_idx} + 6'd1) >= len;

    always_comb begin
        res       = '0;
        res.nxt   = cur;
        if (first) begin
            res.nxt.column      = 6'd0;
            res.nxt.blanking    = cfg.suppress;
            res.nxt.cur_pending = cfg.currency & cfg.suppress;
            if (cfg.currency && !cfg.suppress) begin
                res = push(res, bcdf_pkg::CODE_CURRENCY);
            end
        end
        res = put_digit(res, bcd_byte[7:4], cfg.left);
        res = put_digit(res, bcd_byte[3:0], cfg.left);
        // All-zero blanked number: back up if right-aligned, then write any pending currency and a single zero
        if (last) begin
            if (res.nxt.blanking) begin
                if (!cfg.left) begin
                    res.nxt.column = res.nxt.column - 6'd1;
                end
                if (res.nxt.cur_pending) begin
                    res = push(res, bcdf_pkg::CODE_CURRENCY);
                end
                res = push(res, bcdf_pkg::CODE_ZERO);
            end
            res.nxt.byte_idx = 5'd0;
        end else begin
            res.nxt.byte_idx = cur.byte_idx + 5'd1;
        end
        res.done = last;
    end

endmodule

// ----- hw/rtl/bcdf_checker.sv -----
// Port-level checks for the BCD digit formatter, bound to the top level.
// Depends on bcdf_pkg.
module bcdf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // A stalled write holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("write changed while stalled");

    // End of number is always the end of a byte's writes
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("number end without byte end");

    // Only digit, currency or space codes, or codes 00..05, appear
    a_code_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[13:6] >= bcdf_pkg::CODE_ZERO) || (m_tdata[13:6] <= 8'h05) ||
                     (m_tdata[13:6] == bcdf_pkg::CODE_CURRENCY) ||
                     (m_tdata[13:6] == bcdf_pkg::CODE_SPACE))
        else $error("illegal character code");

    // Nothing is offered right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // Padding bits stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:14] == 2'b00)
        else $error("nonzero padding");

endmodule

bind bcd_digit_formatter_unit bcdf_checker u_bcdf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
